/* src/met_pkg.sv */
// met_pkg: shared types and constants for the escape-time block
// sequencer state codes, multiplier step codes and the shade mapping
// no dependencies
package met_pkg;

    // iteration limit after reset
    localparam logic [11:0] MAX_ITER_RESET = 12'd256;

    // escape radius 64, compared as squared magnitude 4096 = 2^12
    localparam int ESC_R2_LOG2 = 12;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SQ_RE  = 6'b000010,
        S_SQ_IM  = 6'b000100,
        S_TEST   = 6'b001000,
        S_CROSS  = 6'b010000,
        S_UPDATE = 6'b100000
    } met_state_t;

    // partial product order of the shared multiplier
    typedef logic [1:0] met_step_t;
    localparam met_step_t STEP_LO_LO = 2'd0;
    localparam met_step_t STEP_LO_HI = 2'd1;
    localparam met_step_t STEP_HI_LO = 2'd2;
    localparam met_step_t STEP_HI_HI = 2'd3;

    // count / 8, saturated at 15
    function automatic logic [3:0] met_shade(input logic [11:0] n);
        logic [3:0] s;
        if (n[11:7] != 5'd0)
        begin
            s = 4'd15;
        end
        else
        begin
            s = n[6:3];
        end
        return s;
    endfunction

endpackage

/* src/mandelbrot_escape_time.sv */
// mandelbrot_escape_time: escape-time iteration for one point c
// sequencer around one shared multiplier (met_mul)
// depends on met_pkg and met_mul
//
// usage
//   start/busy: a word (c_real, c_imag) is taken at a clock edge with start
//   high and busy low. c parts are signed fixed point, FRAC_BITS fraction bits
//   done: strobes for exactly one cycle with iter_count and shade_index; the
//   receiver cannot hold it off, so it must take the word in that cycle
//   cfg_we/cfg_wdata: writes max_iter, only while busy is low and no word
//   is pending
// timing
//   each iteration uses the multiplier three times (re*re, im*im, re*im),
//   four cycles a product, plus a test cycle and an update cycle: 14 cycles
//   done strobes 14*n - 4 cycles after the taking edge for a count of n;
//   with max_iter at zero it strobes on the next cycle with a count of zero
//   busy stays high until the result is out; the next word may be taken
//   during the done cycle
// reset
//   rst_n clears the sequencer and loads max_iter with 256
module mandelbrot_escape_time
    import met_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] c_real,
    input  logic signed [31:0] c_imag,
    input  logic               cfg_we,
    input  logic [11:0]        cfg_wdata,
    output logic               done,
    output logic [11:0]        iter_count,
    output logic [3:0]         shade_index
);

    // z width: enough for |z*z| <= 8192 plus the widest c
    localparam int ZW        = ((FRAC_BITS + 15) > 33) ? (FRAC_BITS + 15) : 33;
    localparam int PW        = 2 * ZW;
    localparam int ESC_SHIFT = ESC_R2_LOG2 + 2 * FRAC_BITS;
    localparam logic [PW-1:0] ESC_LIMIT = PW'(1) << ESC_SHIFT;

    met_state_t state_reg;
    met_state_t state_next;

    logic signed [ZW-1:0] re_reg;
    logic signed [ZW-1:0] re_next;
    logic signed [ZW-1:0] im_reg;
    logic signed [ZW-1:0] im_next;
    logic signed [31:0]   cr_reg;
    logic signed [31:0]   cr_next;
    logic signed [31:0]   ci_reg;
    logic signed [31:0]   ci_next;
    logic signed [PW-1:0] rr_reg;
    logic signed [PW-1:0] rr_next;
    logic signed [PW-1:0] ii_reg;
    logic signed [PW-1:0] ii_next;
    logic [11:0]          count_reg;
    logic [11:0]          count_next;
    logic [11:0]          max_iter_reg;
    logic                 done_reg;
    logic                 done_next;
    logic [11:0]          iter_count_reg;
    logic [11:0]          iter_count_next;
    logic [3:0]           shade_reg;
    logic [3:0]           shade_next;

    logic                 mul_run;
    logic                 mul_last;
    logic signed [ZW-1:0] mul_a;
    logic signed [ZW-1:0] mul_b;
    logic signed [PW-1:0] mul_prod;

    logic [PW-1:0]        esc_sum;
    logic                 escaped;
    logic signed [PW-1:0] zr_diff;
    logic signed [PW-1:0] zr_shift;
    logic signed [PW-1:0] zi_dbl;
    logic signed [PW-1:0] zi_shift;
    logic signed [ZW-1:0] re_upd;
    logic signed [ZW-1:0] im_upd;

    assign mul_run = (state_reg == S_SQ_RE) || (state_reg == S_SQ_IM)
                  || (state_reg == S_CROSS);
    assign mul_a   = (state_reg == S_SQ_IM) ? im_reg : re_reg;
    assign mul_b   = (state_reg == S_SQ_RE) ? re_reg : im_reg;

    met_mul #(
        .W (ZW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .run   (mul_run),
        .a     (mul_a),
        .b     (mul_b),
        .last  (mul_last),
        .prod  (mul_prod)
    );

    // both squares are non-negative, so the sum cannot wrap
    assign esc_sum = rr_reg + mul_prod;
    assign escaped = esc_sum > ESC_LIMIT;

    // floor of the scaled values by arithmetic shift
    assign zr_diff  = rr_reg - ii_reg;
    assign zr_shift = zr_diff >>> FRAC_BITS;
    assign zi_dbl   = {mul_prod[PW-2:0], 1'b0};
    assign zi_shift = zi_dbl >>> FRAC_BITS;
    assign re_upd   = zr_shift[ZW-1:0] + ZW'(cr_reg);
    assign im_upd   = zi_shift[ZW-1:0] + ZW'(ci_reg);

    always_comb
    begin
        state_next      = state_reg;
        re_next         = re_reg;
        im_next         = im_reg;
        cr_next         = cr_reg;
        ci_next         = ci_reg;
        rr_next         = rr_reg;
        ii_next         = ii_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        iter_count_next = iter_count_reg;
        shade_next      = shade_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (max_iter_reg == 12'd0)
                    begin
                        done_next       = 1'b1;
                        iter_count_next = 12'd0;
                        shade_next      = 4'd0;
                    end
                    else
                    begin
                        // first iteration from z = 0 leaves z = c
                        re_next    = ZW'(c_real);
                        im_next    = ZW'(c_imag);
                        cr_next    = c_real;
                        ci_next    = c_imag;
                        count_next = 12'd1;
                        state_next = S_SQ_RE;
                    end
                end
            end
            S_SQ_RE:
            begin
                if (mul_last)
                begin
                    state_next = S_SQ_IM;
                end
            end
            S_SQ_IM:
            begin
                // product register still holds re*re until this pass ends
                if (mul_last)
                begin
                    rr_next    = mul_prod;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                ii_next = mul_prod;
                if (escaped || (count_reg == max_iter_reg))
                begin
                    done_next       = 1'b1;
                    iter_count_next = count_reg;
                    shade_next      = met_shade(count_reg);
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_CROSS;
                end
            end
            S_CROSS:
            begin
                if (mul_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                re_next    = re_upd;
                im_next    = im_upd;
                count_next = count_reg + 12'd1;
                state_next = S_SQ_RE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            max_iter_reg <= MAX_ITER_RESET;
            count_reg    <= 12'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                max_iter_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg         <= re_next;
        im_reg         <= im_next;
        cr_reg         <= cr_next;
        ci_reg         <= ci_next;
        rr_reg         <= rr_next;
        ii_reg         <= ii_next;
        iter_count_reg <= iter_count_next;
        shade_reg      <= shade_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign iter_count  = iter_count_reg;
    assign shade_index = shade_reg;

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_TEST || state_reg == S_IDLE))
        else $error("result strobe without a finishing step");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg != 12'd0) && (count_reg <= max_iter_reg))
        else $error("iteration count out of range while busy");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (iter_count <= max_iter_reg))
        else $error("iteration count beyond limit");

    a_start_resp: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted word neither started nor answered");

endmodule

/* src/met_mul.sv */
// met_mul: signed W x W multiplier built from four half-width partial products
// one partial product and one accumulate per cycle while run is high, product registered
// depends on met_pkg for the step codes
module met_mul
    import met_pkg::*;
#(
    parameter int W = 43
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  run,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic                  last,
    output logic signed [2*W-1:0] prod
);

    localparam int H  = (W + 1) / 2;
    localparam int HW = W - H;
    localparam int OW = H + 1;
    localparam int AW = 2 * W + 2;
    localparam int PW = 2 * W;

    met_step_t step_reg;
    met_step_t step_next;

    logic signed [OW-1:0]   a_lo;
    logic signed [OW-1:0]   a_hi;
    logic signed [OW-1:0]   b_lo;
    logic signed [OW-1:0]   b_hi;
    logic signed [OW-1:0]   a_op;
    logic signed [OW-1:0]   b_op;
    logic signed [2*OW-1:0] pp;
    logic signed [AW-1:0]   pp_ext;
    logic signed [AW-1:0]   pp_sh;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   acc_next;
    logic signed [PW-1:0]   prod_reg;

    // low halves are unsigned digits, high halves carry the sign
    assign a_lo = {1'b0, a[H-1:0]};
    assign b_lo = {1'b0, b[H-1:0]};
    assign a_hi = {{(OW - HW){a[W-1]}}, a[W-1:H]};
    assign b_hi = {{(OW - HW){b[W-1]}}, b[W-1:H]};

    assign a_op = step_reg[1] ? a_hi : a_lo;
    assign b_op = step_reg[0] ? b_hi : b_lo;

    assign pp     = (2 * OW)'(a_op) * (2 * OW)'(b_op);
    assign pp_ext = AW'(pp);

    always_comb
    begin
        case (step_reg) inside
            STEP_LO_LO:             pp_sh = pp_ext;
            STEP_LO_HI, STEP_HI_LO: pp_sh = pp_ext <<< H;
            STEP_HI_HI:             pp_sh = pp_ext <<< (2 * H);
            default:                pp_sh = pp_ext;
        endcase
    end

    assign acc_next  = ((step_reg == STEP_LO_LO) ? '0 : acc_reg) + pp_sh;
    assign step_next = run ? met_step_t'(step_reg + 2'd1) : STEP_LO_LO;
    assign last      = run && (step_reg == STEP_HI_HI);
    assign prod      = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LO_LO;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (last)
        begin
            prod_reg <= acc_next[PW-1:0];
        end
    end

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !run |=> (step_reg == STEP_LO_LO))
        else $error("multiplier step not cleared when idle");

    a_step_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        last && run |=> (step_reg == STEP_LO_LO))
        else $error("multiplier step did not wrap after last partial product");

    a_step_adv: assert property (@(posedge clk) disable iff (!rst_n)
        run && !last |=> (step_reg == met_step_t'($past(step_reg) + 2'd1)))
        else $error("multiplier step did not advance");

endmodule

/* dv/mandelbrot_escape_time_test.sv */
// mandelbrot_escape_time_test: self-checking bench for the escape-time block
// a scoreboard class predicts iteration count and shade for every accepted word
// depends on met_pkg and mandelbrot_escape_time
module mandelbrot_escape_time_test
    import met_pkg::*;
();

    localparam int FRAC = 28;
    localparam int QUIET_LIMIT = 200000;

    typedef struct packed {
        logic [11:0] count;
        logic [3:0]  shade;
    } escape_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } point_t;

    class escape_scoreboard;
        escape_t     expected_escapes[$];
        logic [11:0] limit;
        int          mismatches;

        function new();
            limit = MAX_ITER_RESET;
            mismatches = 0;
        endfunction

        function automatic escape_t escape_time(logic signed [31:0] cr, logic signed [31:0] ci);
            logic signed [63:0]  re;
            logic signed [63:0]  im;
            logic signed [63:0]  cre;
            logic signed [63:0]  cim;
            logic signed [127:0] rr;
            logic signed [127:0] ii;
            logic signed [127:0] ri;
            logic signed [127:0] mag;
            logic signed [127:0] radius_sq;
            escape_t             e;
            re = '0;
            im = '0;
            cre = cr;
            cim = ci;
            radius_sq = 128'sd1 <<< (ESC_R2_LOG2 + 2 * FRAC);
            e.count = '0;
            for (int k = 1; k <= int'(limit); k++)
            begin
                rr = re * re;
                ii = im * im;
                ri = re * im;
                // arithmetic shift gives the floor of the scaled value
                re = ((rr - ii) >>> FRAC) + cre;
                im = ((ri + ri) >>> FRAC) + cim;
                e.count = k[11:0];
                rr = re * re;
                ii = im * im;
                mag = rr + ii;
                if (mag > radius_sq)
                begin
                    break;
                end
            end
            e.shade = (e.count >= 12'd120) ? 4'd15 : e.count[6:3];
            return e;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function void note_point(logic signed [31:0] cr, logic signed [31:0] ci);
            expected_escapes.push_back(escape_time(cr, ci));
        endfunction

        task check_result(logic [11:0] count, logic [3:0] shade);
            escape_t e;
            if (expected_escapes.size() == 0)
            begin
                report($sformatf("unexpected word count %0d shade %0d", count, shade));
            end
            else
            begin
                e = expected_escapes.pop_front();
                if (count !== e.count)
                begin
                    report($sformatf("iter_count %0d, expected %0d", count, e.count));
                end
                if (shade !== e.shade)
                begin
                    report($sformatf("shade_index %0d, expected %0d", shade, e.shade));
                end
            end
        endtask

        function int pending();
            return expected_escapes.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic               cfg_we;
    logic [11:0]        cfg_wdata;
    logic               done;
    logic [11:0]        iter_count;
    logic [3:0]         shade_index;

    escape_scoreboard sb;
    int               quiet_cycles;

    mandelbrot_escape_time #(
        .FRAC_BITS  (FRAC)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .c_real     (c_real),
        .c_imag     (c_imag),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .iter_count (iter_count),
        .shade_index(shade_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // words in and out, sampled with their pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_point(c_real, c_imag);
            end
            if (done)
            begin
                sb.check_result(iter_count, shade_index);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_point(input point_t p);
        start  <= 1'b1;
        c_real <= p.re;
        c_imag <= p.im;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // bursts of words with random gaps; start stays high inside a burst
    task automatic feed(input point_t pts[$]);
        int burst;
        burst = $urandom_range(1, 12);
        foreach (pts[k])
        begin
            send_point(pts[k]);
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
            end
        end
        start <= 1'b0;
    endtask

    task automatic set_limit(input logic [11:0] v);
        // let the last accepted word reach the scoreboard first
        @(posedge clk);
        while (sb.pending() != 0 || busy)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.limit = v;
    endtask

    function automatic point_t pick_point(input bit wide_only);
        point_t             p;
        logic signed [31:0] edges[7];
        int                 mode;
        edges = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh1, -32'sh1,
                  32'sh1000_0000, 32'shE000_0000};
        mode = wide_only ? 6 : $urandom_range(0, 9);
        if (mode <= 5)
        begin
            // box around the set: real -2.0 .. 0.5, imag -1.25 .. 1.25
            p.re = $urandom_range(0, 671088640) - 536870912;
            p.im = $urandom_range(0, 671088640) - 335544320;
        end
        else if (mode <= 7)
        begin
            p.re = $urandom;
            p.im = $urandom;
        end
        else if (mode == 8)
        begin
            p.re = $urandom;
            p.im = $urandom;
            p.re = p.re >>> $urandom_range(0, 31);
            p.im = p.im >>> $urandom_range(0, 31);
        end
        else
        begin
            p.re = edges[$urandom_range(0, 6)];
            p.im = edges[$urandom_range(0, 6)];
        end
        return p;
    endfunction

    initial
    begin
        point_t      pts[$];
        int          sent;
        int          n;
        logic [11:0] lim;
        sb = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        c_real    = '0;
        c_imag    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: origin, extremes, points on and near the boundary
        pts = '{'{32'sh0, 32'sh0}, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
                '{32'sh8000_0000, 32'sh8000_0000}, '{32'sh8000_0000, 32'sh0},
                '{32'sh7FFF_FFFF, 32'sh8000_0000}, '{32'shE000_0000, 32'sh0},
                '{32'sh0400_0000, 32'sh0}, '{32'sh0, 32'sh1000_0000},
                '{32'shF400_0000, 32'sh0199_999A}, '{32'sh0428_F5C3, 32'sh0},
                '{32'sh1, -32'sh1}};
        feed(pts);

        // zero limit gives a zero count at once
        set_limit(12'd0);
        pts = '{'{32'sh0, 32'sh0}, '{32'sh7FFF_FFFF, 32'sh8000_0000}};
        feed(pts);

        set_limit(12'd1);
        pts = '{'{32'sh0, 32'sh0}, '{32'sh8000_0000, 32'sh8000_0000},
                '{32'sh7FFF_FFFF, 32'sh0}};
        feed(pts);

        set_limit(12'd4095);
        pts = '{'{32'sh0, 32'sh0}, '{32'sh0428_F5C3, 32'sh0},
                '{32'sh8000_0000, 32'sh7FFF_FFFF}};
        feed(pts);

        sent = 0;
        while (sent < 760)
        begin
            case ($urandom_range(0, 9))
                0: lim = 12'd0;
                1: lim = 12'd1;
                8: lim = 12'($urandom_range(100, 300));
                9: lim = 12'd4095;
                default: lim = 12'($urandom_range(2, 64));
            endcase
            set_limit(lim);
            n = (lim == 12'd4095) ? 8 : (lim > 12'd96) ? 16 : 60;
            pts.delete();
            repeat (n) pts.push_back(pick_point(lim == 12'd4095));
            feed(pts);
            sent += n;
        end

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        // room for a stray strobe
        repeat (64) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* mandelbrot_escape_time.f */
src/met_pkg.sv
src/met_mul.sv
src/mandelbrot_escape_time.sv
dv/mandelbrot_escape_time_test.sv
